### rtl/ctf_pkg.sv
`default_nettype none
package ctf_pkg;

	localparam int VEC_W     = 42;
	localparam int Z_W       = 32;
	localparam int VEC_SHIFT = 24;
	localparam int ATAN_N    = 24;

	localparam logic signed [14:0] POS_HALF_PI = 15'sd12868;
	localparam logic signed [14:0] NEG_HALF_PI = -15'sd12868;
	localparam logic signed [15:0] POS_CLAMP   = 16'sd12868;
	localparam logic signed [15:0] NEG_CLAMP   = -16'sd12868;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_GYRO_WEIGHT     = 2'd0;
	localparam reg_index_t REG_PITCH_RATE_BIAS = 2'd1;
	localparam reg_index_t REG_ROLL_RATE_BIAS  = 2'd2;
	localparam reg_index_t REG_RATE_TICK_SCALE = 2'd3;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [Z_W-1:0]   z;
	} lane_t;

	typedef struct packed {
		logic              special;
		logic              undef;
		logic signed [14:0] value;
	} tilt_spec_t;

	localparam logic [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
		32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
		32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
		32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
		32'd131072,    32'd65536,     32'd32768,     32'd16384,
		32'd8192,      32'd4096,      32'd2048,      32'd1024,
		32'd512,       32'd256,       32'd128,       32'd64
	};

	function automatic tilt_spec_t tilt_spec(input logic signed [15:0] num,
			input logic signed [15:0] den);
		tilt_spec_t s;
		s.special = (den == 16'sd0) || (num == 16'sd0);
		s.undef   = (den == 16'sd0) && (num == 16'sd0);
		s.value   = 15'sd0;
		if ((den == 16'sd0) && (num != 16'sd0)) begin
			s.value = num[15] ? NEG_HALF_PI : POS_HALF_PI;
		end
		return s;
	endfunction

	function automatic lane_t lane_init(input logic signed [15:0] num,
			input logic signed [15:0] den);
		lane_t l;
		logic signed [16:0] n;
		logic signed [16:0] d;
		n = {num[15], num};
		d = {den[15], den};
		if (den[15]) begin
			n = -n;
			d = -d;
		end
		l.x = {d[16], d, {VEC_SHIFT{1'b0}}};
		l.y = {n[16], n, {VEC_SHIFT{1'b0}}};
		l.z = '0;
		return l;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/ctf_cordic_cell.sv
`default_nettype none
module ctf_cordic_cell
	import ctf_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire lane_t [1:0] in_lanes,
	output logic             out_valid,
	output lane_t [1:0]      out_lanes
);

	logic        valid_q;
	lane_t [1:0] lanes_q;
	lane_t [1:0] nxt;

	always_comb begin
		logic signed [VEC_W-1:0] xs;
		logic signed [VEC_W-1:0] ys;
		logic signed [Z_W-1:0]   ang;
		ang = $signed(ATAN_TAB[STEP]);
		for (int l = 0; l < 2; l++) begin
			xs = $signed(in_lanes[l].x) >>> STEP;
			ys = $signed(in_lanes[l].y) >>> STEP;
			if (!in_lanes[l].y[VEC_W-1]) begin
				nxt[l].x = in_lanes[l].x + ys;
				nxt[l].y = in_lanes[l].y - xs;
				nxt[l].z = in_lanes[l].z + ang;
			end else begin
				nxt[l].x = in_lanes[l].x - ys;
				nxt[l].y = in_lanes[l].y + xs;
				nxt[l].z = in_lanes[l].z - ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;

endmodule
`default_nettype wire

### rtl/ctf_axis.sv
`default_nettype none
module ctf_axis
	import ctf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] num,
	input  wire logic signed [15:0] den,
	input  wire logic signed [15:0] rate,
	input  wire logic signed [15:0] bias,
	input  wire logic        [15:0] ticks,
	input  wire logic        [31:0] scale,
	input  wire logic        [15:0] weight,
	input  wire logic               tilt_valid,
	input  wire logic signed [Z_W-1:0] tilt_z,
	output logic                    done,
	output logic signed [15:0]      estimate,
	output logic signed [15:0]      from_gyro,
	output logic signed [14:0]      from_accel,
	output logic                    undef
);

	tilt_spec_t         spec_q;
	logic               gyro_v_s1;
	logic signed [33:0] prod_s1;
	logic               gyro_v_s2;
	logic               neg_s2;
	logic        [63:0] mag_s2;
	logic signed [15:0] gyro_q;
	logic signed [15:0] angle_q;

	logic               blend_v_s1;
	logic signed [14:0] accel_q;
	logic               undef_q;
	logic               blend_v_s2;
	logic signed [32:0] wg_s2;
	logic signed [32:0] wa_s2;
	logic               done_q;

	logic signed [16:0] rate_sum;
	logic signed [33:0] rate_prod;
	logic signed [33:0] prod_abs;
	logic        [47:0] rnd;
	logic        [16:0] clip;
	logic signed [17:0] delta;
	logic signed [17:0] gyro_sum;
	logic signed [Z_W-1:0] z_rnd;
	logic signed [15:0] z_q13;
	logic signed [14:0] accel_next;
	logic        [16:0] comp_w;
	logic signed [33:0] blend_sum;
	logic signed [17:0] blend_sh;

	always_comb begin
		rate_sum  = {rate[15], rate} + {bias[15], bias};
		rate_prod = rate_sum * $signed({1'b0, ticks});
		prod_abs  = prod_s1[33] ? -prod_s1 : prod_s1;

		rnd      = 48'((mag_s2 + 64'd32768) >> 16);
		clip     = (rnd > 48'd65536) ? 17'd65536 : rnd[16:0];
		delta    = neg_s2 ? -$signed({1'b0, clip}) : $signed({1'b0, clip});
		gyro_sum = {{2{angle_q[15]}}, angle_q} + delta;

		z_rnd = tilt_z + 32'sd32768;
		z_q13 = z_rnd[Z_W-1:16];
		if (spec_q.special) begin
			accel_next = spec_q.value;
		end else if (z_q13 > POS_CLAMP) begin
			accel_next = POS_HALF_PI;
		end else if (z_q13 < NEG_CLAMP) begin
			accel_next = NEG_HALF_PI;
		end else begin
			accel_next = z_q13[14:0];
		end

		comp_w    = 17'h10000 - {1'b0, weight};
		blend_sum = {wg_s2[32], wg_s2} + {wa_s2[32], wa_s2} + 34'sd32768;
		blend_sh  = blend_sum[33:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_v_s1  <= 1'b0;
			gyro_v_s2  <= 1'b0;
			blend_v_s1 <= 1'b0;
			blend_v_s2 <= 1'b0;
			done_q     <= 1'b0;
			angle_q    <= '0;
		end else begin
			gyro_v_s1  <= start;
			gyro_v_s2  <= gyro_v_s1;
			blend_v_s1 <= tilt_valid;
			blend_v_s2 <= blend_v_s1;
			done_q     <= blend_v_s2;
			if (blend_v_s2) begin
				angle_q <= sat16(blend_sh);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			spec_q  <= tilt_spec(num, den);
			prod_s1 <= rate_prod;
		end
		if (gyro_v_s1) begin
			neg_s2 <= prod_s1[33];
			mag_s2 <= 64'(prod_abs[31:0]) * 64'(scale);
		end
		if (gyro_v_s2) begin
			gyro_q <= sat16(gyro_sum);
		end
		if (tilt_valid) begin
			accel_q <= accel_next;
			undef_q <= spec_q.undef;
		end
		if (blend_v_s1) begin
			wg_s2 <= $signed({1'b0, weight}) * gyro_q;
			wa_s2 <= $signed({1'b0, comp_w}) * accel_q;
		end
	end

	assign done       = done_q;
	assign estimate   = angle_q;
	assign from_gyro  = gyro_q;
	assign from_accel = accel_q;
	assign undef      = undef_q;

endmodule
`default_nettype wire

### rtl/imu_complementary_tilt_filter.sv
// Pitch and roll tilt filter for one IMU sample stream.
// Input channel: in_valid/in_stall carry three accelerations, two gyro rates
// and the tick count since the previous sample. Output channel:
// out_valid/out_stall carry blended pitch and roll, their gyro and
// accelerometer parts, and the two 0/0 flags.
// Config port: cfg_write_en with cfg_index and cfg_data writes gyro_weight,
// pitch_rate_bias, roll_rate_bias or rate_tick_scale; write only while idle.
// A sample passes through the row of CORDIC cells, one micro-rotation per
// cell, that both tilt angles pass through, followed by the rounding and
// blend registers and the output register. The gyro integration runs in
// parallel and finishes before the blend.
// in_stall is high from a transfer until its result enters the output
// register. While the receiver stalls, the result holds there and the next
// sample is still accepted; its result waits in the filter until the output
// register frees.
// Reset clears the pitch and roll state, loads the register defaults and
// drops any sample in flight.
`default_nettype none
module imu_complementary_tilt_filter
	import ctf_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] rate_about_x,
	input  wire logic signed [15:0] rate_about_y,
	input  wire logic        [15:0] elapsed_ticks,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      pitch_estimate,
	output logic signed [15:0]      roll_estimate,
	output logic signed [15:0]      pitch_from_gyro,
	output logic signed [15:0]      roll_from_gyro,
	output logic signed [14:0]      pitch_from_accel,
	output logic signed [14:0]      roll_from_accel,
	output logic        [1:0]       tilt_undefined,
	input  wire logic               cfg_write_en,
	input  wire reg_index_t         cfg_index,
	input  wire logic        [31:0] cfg_data
);

	logic        [15:0] gyro_weight_q;
	logic signed [15:0] pitch_rate_bias_q;
	logic signed [15:0] roll_rate_bias_q;
	logic        [31:0] rate_tick_scale_q;

	logic busy_q;
	logic res_valid_q;
	logic out_valid_q;
	logic in_xfer;
	logic move;

	lane_t [1:0] link [CORDIC_STEPS+1];
	logic        link_v [CORDIC_STEPS+1];

	logic               pitch_done;
	logic               roll_done;
	logic signed [15:0] p_est, r_est, p_gyro, r_gyro;
	logic signed [14:0] p_acc, r_acc;
	logic               p_undef, r_undef;

	logic signed [15:0] pitch_estimate_q, roll_estimate_q;
	logic signed [15:0] pitch_from_gyro_q, roll_from_gyro_q;
	logic signed [14:0] pitch_from_accel_q, roll_from_accel_q;
	logic        [1:0]  tilt_undefined_q;

	assign in_xfer = in_valid && !busy_q;
	assign move    = res_valid_q && (!out_valid_q || !out_stall);

	assign link_v[0]  = in_xfer;
	assign link[0][0] = lane_init(accel_x, accel_z);
	assign link[0][1] = lane_init(accel_y, accel_z);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		ctf_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_v[i]),
			.in_lanes  (link[i]),
			.out_valid (link_v[i+1]),
			.out_lanes (link[i+1])
		);
	end

	ctf_axis u_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_xfer),
		.num        (accel_x),
		.den        (accel_z),
		.rate       (rate_about_y),
		.bias       (pitch_rate_bias_q),
		.ticks      (elapsed_ticks),
		.scale      (rate_tick_scale_q),
		.weight     (gyro_weight_q),
		.tilt_valid (link_v[CORDIC_STEPS]),
		.tilt_z     (link[CORDIC_STEPS][0].z),
		.done       (pitch_done),
		.estimate   (p_est),
		.from_gyro  (p_gyro),
		.from_accel (p_acc),
		.undef      (p_undef)
	);

	ctf_axis u_roll (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_xfer),
		.num        (accel_y),
		.den        (accel_z),
		.rate       (rate_about_x),
		.bias       (roll_rate_bias_q),
		.ticks      (elapsed_ticks),
		.scale      (rate_tick_scale_q),
		.weight     (gyro_weight_q),
		.tilt_valid (link_v[CORDIC_STEPS]),
		.tilt_z     (link[CORDIC_STEPS][1].z),
		.done       (roll_done),
		.estimate   (r_est),
		.from_gyro  (r_gyro),
		.from_accel (r_acc),
		.undef      (r_undef)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_weight_q     <= 16'd58982;
			pitch_rate_bias_q <= 16'sd2;
			roll_rate_bias_q  <= 16'sd0;
			rate_tick_scale_q <= 32'd93697;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_GYRO_WEIGHT:     gyro_weight_q     <= cfg_data[15:0];
				REG_PITCH_RATE_BIAS: pitch_rate_bias_q <= cfg_data[15:0];
				REG_ROLL_RATE_BIAS:  roll_rate_bias_q  <= cfg_data[15:0];
				REG_RATE_TICK_SCALE: rate_tick_scale_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (pitch_done && roll_done) begin
				res_valid_q <= 1'b1;
			end else if (move) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			pitch_estimate_q   <= p_est;
			roll_estimate_q    <= r_est;
			pitch_from_gyro_q  <= p_gyro;
			roll_from_gyro_q   <= r_gyro;
			pitch_from_accel_q <= p_acc;
			roll_from_accel_q  <= r_acc;
			tilt_undefined_q   <= {r_undef, p_undef};
		end
	end

	assign in_stall         = busy_q;
	assign out_valid        = out_valid_q;
	assign pitch_estimate   = pitch_estimate_q;
	assign roll_estimate    = roll_estimate_q;
	assign pitch_from_gyro  = pitch_from_gyro_q;
	assign roll_from_gyro   = roll_from_gyro_q;
	assign pitch_from_accel = pitch_from_accel_q;
	assign roll_from_accel  = roll_from_accel_q;
	assign tilt_undefined   = tilt_undefined_q;

endmodule
`default_nettype wire

### rtl/ctf_checker.sv
`default_nettype none
module ctf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] pitch_estimate,
	input wire logic signed [15:0] roll_estimate,
	input wire logic signed [14:0] pitch_from_accel,
	input wire logic signed [14:0] roll_from_accel,
	input wire logic        [1:0]  tilt_undefined
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a sample is in flight");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result delivered but input still stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pitch_estimate)
			&& $stable(roll_estimate) && $stable(tilt_undefined))
		else $error("stalled result changed");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!tilt_undefined[0] || pitch_from_accel == 15'sd0)
			&& (!tilt_undefined[1] || roll_from_accel == 15'sd0))
		else $error("undefined tilt angle is not zero");

	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_from_accel <= 15'sd12868 && pitch_from_accel >= -15'sd12868
			&& roll_from_accel <= 15'sd12868 && roll_from_accel >= -15'sd12868)
		else $error("accelerometer tilt beyond half pi");

endmodule

bind imu_complementary_tilt_filter ctf_checker u_ctf_checker (.*);
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ctf_pkg::*;

	localparam int CORDIC_STEPS  = 16;
	localparam int HALF_PI       = 12868;
	localparam int PHASE_A_END   = 330;
	localparam int PHASE_B_END   = 660;
	localparam int SETTLE_CYCLES = 48;
	localparam int QUIET_LIMIT   = 4000;

	typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_HOLD} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic        [15:0] ticks;
		reg_index_t         idx;
		logic        [31:0] data;
	} op_t;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [15:0] pitch_gyro;
		logic signed [15:0] roll_gyro;
		logic signed [14:0] pitch_accel;
		logic signed [14:0] roll_accel;
		logic        [1:0]  undef_flags;
	} tilt_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] rate_about_x = '0;
	logic signed [15:0] rate_about_y = '0;
	logic        [15:0] elapsed_ticks = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] pitch_estimate;
	logic signed [15:0] roll_estimate;
	logic signed [15:0] pitch_from_gyro;
	logic signed [15:0] roll_from_gyro;
	logic signed [14:0] pitch_from_accel;
	logic signed [14:0] roll_from_accel;
	logic        [1:0]  tilt_undefined;
	logic               cfg_write_en = 1'b0;
	reg_index_t         cfg_index = REG_GYRO_WEIGHT;
	logic        [31:0] cfg_data = '0;

	op_t          ops [$];
	tilt_result_t expected_q [$];
	int           sent = 0;
	int           seen = 0;
	int           errors = 0;
	int           quiet_cycles = 0;

	int          gyro_w = 58982;
	int          pitch_bias = 2;
	int          roll_bias = 0;
	int unsigned tick_scale = 93697;
	int          pitch_state = 0;
	int          roll_state = 0;

	longint cordic_angle [24] = '{
		421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
		8387925, 4194219, 2097141, 1048575, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096,
		2048, 1024, 512, 256, 128, 64
	};

	imu_complementary_tilt_filter #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.rate_about_x(rate_about_x),
		.rate_about_y(rate_about_y),
		.elapsed_ticks(elapsed_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pitch_estimate(pitch_estimate),
		.roll_estimate(roll_estimate),
		.pitch_from_gyro(pitch_from_gyro),
		.roll_from_gyro(roll_from_gyro),
		.pitch_from_accel(pitch_from_accel),
		.roll_from_accel(roll_from_accel),
		.tilt_undefined(tilt_undefined),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic int accel_tilt(input int num, input int den, output bit undef);
		longint x, y, z, xs, ys;
		int n, d, i;
		undef = 1'b0;
		n = num;
		d = den;
		if (d == 0) begin
			undef = (n == 0);
			if (n == 0) return 0;
			return (n > 0) ? HALF_PI : -HALF_PI;
		end
		if (n == 0) return 0;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		x = longint'(d) * 16777216;
		y = longint'(n) * 16777216;
		z = 0;
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + cordic_angle[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - cordic_angle[i];
			end
		end
		z = (z + 32768) >>> 16;
		if (z > HALF_PI) z = HALF_PI;
		if (z < -HALF_PI) z = -HALF_PI;
		return int'(z);
	endfunction

	function automatic int gyro_advance(input int prev, input int rate, input int bias,
			input int ticks);
		longint          p;
		longint unsigned mag;
		longint          d;
		p = longint'(rate + bias) * longint'(ticks);
		mag = (p < 0) ? -p : p;
		mag = mag * {32'd0, tick_scale};
		mag = (mag + 64'd32768) >> 16;
		if (mag > 64'd65536) mag = 64'd65536;
		d = longint'(mag);
		if (p < 0) d = -d;
		return clamp16(longint'(prev) + d);
	endfunction

	function automatic int mix_angles(input int g, input int a);
		longint s;
		s = longint'(gyro_w) * g + longint'(65536 - gyro_w) * a;
		return clamp16((s + 32768) >>> 16);
	endfunction

	function automatic tilt_result_t advance_filter(input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az,
			input logic signed [15:0] rx, input logic signed [15:0] ry,
			input logic [15:0] ticks);
		tilt_result_t r;
		bit           up, ur;
		int           pa, ra, pg, rg;
		pa = accel_tilt(int'(ax), int'(az), up);
		ra = accel_tilt(int'(ay), int'(az), ur);
		pg = gyro_advance(pitch_state, int'(ry), pitch_bias, int'(ticks));
		rg = gyro_advance(roll_state, int'(rx), roll_bias, int'(ticks));
		pitch_state = mix_angles(pg, pa);
		roll_state = mix_angles(rg, ra);
		r.pitch = pitch_state[15:0];
		r.roll = roll_state[15:0];
		r.pitch_gyro = pg[15:0];
		r.roll_gyro = rg[15:0];
		r.pitch_accel = pa[14:0];
		r.roll_accel = ra[14:0];
		r.undef_flags = {ur, up};
		return r;
	endfunction

	function automatic void load_reg(input reg_index_t idx, input logic [31:0] data);
		case (idx)
			REG_GYRO_WEIGHT: gyro_w = int'(data[15:0]);
			REG_PITCH_RATE_BIAS: pitch_bias = int'($signed(data[15:0]));
			REG_ROLL_RATE_BIAS: roll_bias = int'($signed(data[15:0]));
			REG_RATE_TICK_SCALE: tick_scale = data;
			default: ;
		endcase
	endfunction

	function automatic int gap_pct(input int n);
		if (n < PHASE_A_END) return 9;
		if (n < PHASE_B_END) return 52;
		return 0;
	endfunction

	function automatic int stall_pct(input int n);
		if (n < PHASE_A_END) return 52;
		if (n < PHASE_B_END) return 9;
		return 0;
	endfunction

	function automatic int spread(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic int any16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int corner_value();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return -32768;
			2: return 32767;
			3: return 1;
			4: return -1;
			default: return any16();
		endcase
	endfunction

	task automatic push_sample(input int ax, input int ay, input int az, input int rx,
			input int ry, input int ticks);
		op_t o;
		o = '0;
		o.kind = OP_SAMPLE;
		o.ax = ax[15:0];
		o.ay = ay[15:0];
		o.az = az[15:0];
		o.rx = rx[15:0];
		o.ry = ry[15:0];
		o.ticks = ticks[15:0];
		ops.push_back(o);
	endtask

	task automatic push_write(input reg_index_t idx, input logic [31:0] data);
		op_t o;
		o = '0;
		o.kind = OP_WRITE;
		o.idx = idx;
		o.data = data;
		ops.push_back(o);
	endtask

	task automatic push_hold();
		op_t o;
		o = '0;
		o.kind = OP_HOLD;
		ops.push_back(o);
	endtask

	// upper bits of the 16-bit registers carry junk
	task automatic push_regs(input int w, input int pb, input int rb, input int unsigned scale);
		logic [15:0] junk;
		junk = $urandom_range(0, 65535);
		push_write(REG_GYRO_WEIGHT, {junk, w[15:0]});
		push_write(REG_PITCH_RATE_BIAS, {~junk, pb[15:0]});
		push_write(REG_ROLL_RATE_BIAS, {junk ^ 16'h5A5A, rb[15:0]});
		push_write(REG_RATE_TICK_SCALE, scale);
	endtask

	task automatic push_random_regs();
		push_regs($urandom_range(0, 65535),
			($urandom_range(0, 3) == 0) ? any16() : spread(300),
			($urandom_range(0, 3) == 0) ? any16() : spread(300),
			($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300000));
	endtask

	task automatic push_random_sample();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 50) begin
			push_sample(spread(4096), spread(4096), spread(4600) + 3500, spread(300),
				spread(300), $urandom_range(0, 20));
		end else if (mode < 70) begin
			push_sample(any16(), any16(), any16(), any16(), any16(), $urandom_range(0, 65535));
		end else if (mode < 85) begin
			push_sample(corner_value(), corner_value(),
				($urandom_range(0, 1) == 0) ? 0 : corner_value(), corner_value(),
				corner_value(), ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 40));
		end else begin
			push_sample(spread(3), spread(3), spread(3), spread(3), spread(3),
				$urandom_range(0, 3));
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (errors < 50)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// driver: present queued samples, apply register writes once the filter is idle
	always @(posedge clk or negedge arst_n) begin : drive
		logic nv;
		logic nw;
		op_t  head;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_write_en <= 1'b0;
			gyro_w = 58982;
			pitch_bias = 2;
			roll_bias = 0;
			tick_scale = 93697;
			pitch_state = 0;
			roll_state = 0;
		end else begin
			nv = in_valid;
			nw = 1'b0;
			if (in_valid && !in_stall) begin
				expected_q.push_back(advance_filter(accel_x, accel_y, accel_z,
					rate_about_x, rate_about_y, elapsed_ticks));
				sent <= sent + 1;
				nv = 1'b0;
			end
			if (!nv && ops.size() != 0) begin
				head = ops[0];
				case (head.kind)
					OP_SAMPLE: begin
						if ($urandom_range(0, 99) >= gap_pct(sent)) begin
							accel_x <= head.ax;
							accel_y <= head.ay;
							accel_z <= head.az;
							rate_about_x <= head.rx;
							rate_about_y <= head.ry;
							elapsed_ticks <= head.ticks;
							nv = 1'b1;
							void'(ops.pop_front());
						end
					end
					OP_WRITE: begin
						if (!in_valid && sent == seen) begin
							nw = 1'b1;
							cfg_index <= head.idx;
							cfg_data <= head.data;
							load_reg(head.idx, head.data);
							void'(ops.pop_front());
						end
					end
					default: begin
						if (!in_valid && sent == seen)
							void'(ops.pop_front());
					end
				endcase
			end
			in_valid <= nv;
			cfg_write_en <= nw;
		end
	end

	// monitor: check each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : observe
		tilt_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with no sample pending, pitch_estimate %0d",
						$time, pitch_estimate);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("pitch_estimate", int'(want.pitch), int'(pitch_estimate));
					check_field("roll_estimate", int'(want.roll), int'(roll_estimate));
					check_field("pitch_from_gyro", int'(want.pitch_gyro), int'(pitch_from_gyro));
					check_field("roll_from_gyro", int'(want.roll_gyro), int'(roll_from_gyro));
					check_field("pitch_from_accel", int'(want.pitch_accel),
						int'(pitch_from_accel));
					check_field("roll_from_accel", int'(want.roll_accel), int'(roll_from_accel));
					check_field("tilt_undefined", int'(want.undef_flags), int'(tilt_undefined));
				end
				seen <= seen + 1;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct(sent));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int k, s;

		push_sample(0, 0, 0, 0, 0, 0);
		push_sample(0, 0, 4096, 0, 0, 1);
		push_sample(5, -5, 0, 10, -10, 1);
		push_sample(-32768, 32767, 0, 32767, -32768, 1);
		push_sample(0, 7, 0, 1, 1, 1);
		push_sample(-9, 0, 0, -1, -1, 2);
		push_sample(-32768, 32767, -32768, 0, 0, 0);
		push_sample(1, -1, -1, 3, -3, 5);
		push_sample(32767, -32768, 32767, 0, 0, 1);
		push_sample(1, -1, 32767, 0, 0, 1);
		push_sample(32767, -32768, 1, 0, 0, 1);
		push_sample(4096, -2000, 4096, 0, 0, 1);
		push_sample(0, 0, 4096, 32767, 32767, 65535);
		push_sample(0, 0, 4096, -32768, -32768, 65535);
		push_sample(0, 0, 4096, 1, 1, 1);
		push_sample(100, -100, 4096, 0, -2, 300);
		for (k = 0; k < 3; k++)
			push_sample(0, 0, 4096, 1000, 1000, 100);
		push_sample(0, 0, 4096, 0, 0, 65535);
		push_sample(-1, -1, -1, -1, -1, 65535);
		push_sample(3000, -3000, -4096, 200, -200, 10);

		push_hold();
		push_regs(0, -32768, 32767, 0);
		for (k = 0; k < 60; k++)
			push_random_sample();
		push_regs(65535, 32767, -32768, 32'hFFFF_FFFF);
		for (k = 0; k < 40; k++)
			push_random_sample();
		push_regs(58982, 2, 0, 93697);
		for (k = 0; k < 150; k++)
			push_random_sample();
		push_hold();
		for (k = 0; k < 150; k++)
			push_random_sample();
		for (s = 0; s < 5; s++) begin
			push_random_regs();
			for (k = 0; k < 100; k++)
				push_random_sample();
		end
		push_regs(1, 0, 0, 1);
		for (k = 0; k < 40; k++)
			push_random_sample();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (ops.size() != 0 || in_valid || sent != seen)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
